// ===== rtl/dbsf_pkg.sv =====
`timescale 1ns / 1ps
// dbsf_pkg: shared types and constants of the dedup sample history
// no dependencies; imported by dbsf_ctrl, the top level and the bench

package dbsf_pkg;

  // default sizing handed to the top level parameters
  localparam int unsigned MaxDepthDef   = 16;
  localparam int unsigned HandleBitsDef = 16;

  // fixed field widths
  localparam int unsigned ReqW     = 2;
  localparam int unsigned IdW      = 64;
  localparam int unsigned SeqW     = 64;
  localparam int unsigned KindW    = 2;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned CountW   = 5;

  // request codes
  localparam logic [ReqW-1:0] ReqAdd      = 2'd0;
  localparam logic [ReqW-1:0] ReqTake     = 2'd1;
  localparam logic [ReqW-1:0] ReqContains = 2'd2;

  // register port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegDepthLimit = 1'b0;  // word index of depth_limit
  localparam logic [CountW-1:0] DepthLimitRst = 5'd16;

  // request beat
  typedef struct packed {
    logic [ReqW-1:0]    req_type;
    logic [IdW-1:0]     writer_id_high;
    logic [IdW-1:0]     writer_id_low;
    logic [SeqW-1:0]    seq_num;
    logic [KindW-1:0]   change_kind;
    logic [HandleW-1:0] payload_handle;
  } req_t;

  // response beat
  typedef struct packed {
    logic               ok;
    logic [IdW-1:0]     out_writer_high;
    logic [IdW-1:0]     out_writer_low;
    logic [SeqW-1:0]    out_seq;
    logic [KindW-1:0]   out_kind;
    logic [HandleW-1:0] out_handle;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== rtl/dbsf_ram.sv =====
`timescale 1ns / 1ps
// dbsf_ram: entry ring storage, one write port and one registered read port
// no package dependencies

module dbsf_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dbsf_ctrl.sv =====
`timescale 1ns / 1ps
// dbsf_ctrl: request sequencer with the shared key comparator and ring pointers
// depends on dbsf_pkg; drives the ports of dbsf_ram

module dbsf_ctrl import dbsf_pkg::*; #(
  parameter int unsigned MAX_DEPTH   = MaxDepthDef,
  parameter int unsigned HANDLE_BITS = HandleBitsDef,
  localparam int unsigned PtrW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int unsigned CntW   = $clog2(MAX_DEPTH + 1),
  localparam int unsigned SlotHW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW,
  localparam int unsigned EntryW = 2 * IdW + SeqW + KindW + SlotHW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] depth_limit_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_data_o,
  output logic              ram_we_o,
  output logic [PtrW-1:0]   ram_waddr_o,
  output logic [EntryW-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [PtrW-1:0]   ram_raddr_o,
  input  logic [EntryW-1:0] ram_rdata_i
);

  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_RESOLVE,
    ST_WRITE,
    ST_TAKE,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  rsp_t            res_q, res_d;
  rsp_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] oldest_q, oldest_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic            pipe_vld_q, pipe_vld_d;
  logic            hit_q, hit_d;

  logic [IdW-1:0]    rd_wh;
  logic [IdW-1:0]    rd_wl;
  logic [SeqW-1:0]   rd_seq;
  logic [KindW-1:0]  rd_kind;
  logic [SlotHW-1:0] rd_handle;
  logic              key_hit;
  logic [CmpW-1:0]   dl_ext;
  logic [CntW-1:0]   eff_depth;

  // next ring slot
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(MAX_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // ring slot at offset k from p, k no more than the ring size
  function automatic logic [PtrW-1:0] ring_add(input logic [PtrW-1:0] p,
                                               input logic [CntW-1:0] k);
    logic [SumW-1:0] s;
    s = SumW'(p) + SumW'(k);
    if (s >= SumW'(MAX_DEPTH)) begin
      s = s - SumW'(MAX_DEPTH);
    end
    return s[PtrW-1:0];
  endfunction

  // unpack the entry read back from the ring
  assign rd_wh     = ram_rdata_i[EntryW-1 -: IdW];
  assign rd_wl     = ram_rdata_i[EntryW-IdW-1 -: IdW];
  assign rd_seq    = ram_rdata_i[SlotHW+KindW +: SeqW];
  assign rd_kind   = ram_rdata_i[SlotHW +: KindW];
  assign rd_handle = ram_rdata_i[SlotHW-1:0];

  // shared key comparator
  assign key_hit = (rd_wh == req_q.writer_id_high) &&
                   (rd_wl == req_q.writer_id_low) &&
                   (rd_seq == req_q.seq_num);

  // depth limit clamped to 1..MAX_DEPTH
  assign dl_ext = CmpW'(depth_limit_i);
  always_comb begin
    if (dl_ext == '0) begin
      eff_depth = CntW'(1);
    end else if (dl_ext > CmpW'(MAX_DEPTH)) begin
      eff_depth = CntW'(MAX_DEPTH);
    end else begin
      eff_depth = dl_ext[CntW-1:0];
    end
  end

  // entry written by an add
  assign ram_wdata_o = {req_q.writer_id_high, req_q.writer_id_low, req_q.seq_num,
                        req_q.change_kind, req_q.payload_handle[SlotHW-1:0]};

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    rd_ptr_d    = rd_ptr_q;
    scan_idx_d  = scan_idx_q;
    pipe_vld_d  = pipe_vld_q;
    hit_d       = hit_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ring_add(oldest_q, count_q);
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_ptr_q;

    // response beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_d      = '0;
        hit_d      = 1'b0;
        pipe_vld_d = 1'b0;
        scan_idx_d = '0;
        rd_ptr_d   = oldest_q;
        case (req_q.req_type)
          ReqAdd, ReqContains: begin
            state_d = ST_SCAN;
          end
          ReqTake: begin
            if (count_q == '0) begin
              state_d = ST_FINISH;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = oldest_q;
              state_d     = ST_TAKE;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end

      // one stored entry read per cycle, compared in the cycle after its read
      ST_SCAN: begin
        if (pipe_vld_q && key_hit) begin
          hit_d   = 1'b1;
          state_d = ST_RESOLVE;
        end else if (scan_idx_q != count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rd_ptr_q;
          rd_ptr_d    = ptr_inc(rd_ptr_q);
          scan_idx_d  = scan_idx_q + 1'b1;
          pipe_vld_d  = 1'b1;
        end else if (!pipe_vld_q) begin
          state_d = ST_RESOLVE;
        end else begin
          pipe_vld_d = 1'b0;
        end
      end

      ST_RESOLVE: begin
        if (req_q.req_type == ReqContains) begin
          res_d.ok = hit_q;
          state_d  = ST_FINISH;
        end else if (hit_q) begin
          state_d = ST_FINISH;
        end else begin
          // trim the oldest entries so the new one fits within the limit
          if (count_q >= eff_depth) begin
            oldest_d = ring_add(oldest_q, CntW'(count_q - eff_depth + 1'b1));
            count_d  = CntW'(eff_depth - 1'b1);
          end
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        ram_we_o = 1'b1;
        count_d  = count_q + 1'b1;
        res_d.ok = 1'b1;
        state_d  = ST_FINISH;
      end

      ST_TAKE: begin
        res_d.ok              = 1'b1;
        res_d.out_writer_high = rd_wh;
        res_d.out_writer_low  = rd_wl;
        res_d.out_seq         = rd_seq;
        res_d.out_kind        = rd_kind;
        res_d.out_handle      = HandleW'(rd_handle);
        oldest_d              = ptr_inc(oldest_q);
        count_d               = count_q - 1'b1;
        state_d               = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d             = res_q;
          out_d.entry_count = CountW'(count_q);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      oldest_q    <= '0;
      rd_ptr_q    <= '0;
      scan_idx_q  <= '0;
      pipe_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      rd_ptr_q    <= rd_ptr_d;
      scan_idx_q  <= scan_idx_d;
      pipe_vld_q  <= pipe_vld_d;
      hit_q       <= hit_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/dedup_bounded_sample_fifo.sv =====
`timescale 1ns / 1ps
// Keep-last sample history with a duplicate filter. Requests arrive as beats on
// the input channel. Add stores an entry unless one with the same writer id and
// sequence number is already held, and before storing it trims the oldest
// entries down to the depth limit. Take pops the oldest entry, and contains
// reports a match. Each request yields exactly one response beat that carries
// the entry count. One request is in flight at a time. Add and contains walk the
// stored entries, and a match ends the walk early. A single key comparator walks
// the entry memory one entry per cycle through its one read port. A waiting
// response beat does not block the next request from being accepted, but that
// request holds in its finish state until the output slot frees up. The
// depth_limit register sits at byte address 0 of the APB port; the user must
// write it only while no request is in flight, and the block itself does not
// enforce this. Depends on dbsf_pkg, dbsf_ram and dbsf_ctrl.

module dedup_bounded_sample_fifo import dbsf_pkg::*; #(
  parameter int unsigned MAX_DEPTH   = MaxDepthDef,
  parameter int unsigned HANDLE_BITS = HandleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  req_t                in_data_i,
  // response channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_data_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned PtrW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned SlotHW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int unsigned EntryW = 2 * IdW + SeqW + KindW + SlotHW;

  logic [CountW-1:0] depth_limit_q, depth_limit_d;
  logic              reg_wr;
  logic              ram_we;
  logic [PtrW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [PtrW-1:0]   ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  // register write decode
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == RegDepthLimit);

  always_comb begin
    depth_limit_d = depth_limit_q;
    if (reg_wr) begin
      depth_limit_d = pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DepthLimitRst;
    end else begin
      depth_limit_q <= depth_limit_d;
    end
  end

  // register read back
  assign prdata = (paddr[2] == RegDepthLimit) ? ApbDataW'(depth_limit_q) : '0;
  assign pready = 1'b1;

  // sequencer
  dbsf_ctrl #(
    .MAX_DEPTH   (MAX_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .depth_limit_i (depth_limit_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  // entry ring
  dbsf_ram #(
    .Depth (MAX_DEPTH),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // one request in flight: an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the previous one was still open");

  // a response with ok low carries no entry
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      (out_data_o.out_writer_high == '0) && (out_data_o.out_writer_low == '0) &&
      (out_data_o.out_seq == '0) && (out_data_o.out_kind == '0) &&
      (out_data_o.out_handle == '0))
    else $error("entry fields set on a response with ok low");

  // the count never passes the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.entry_count) <= MAX_DEPTH))
    else $error("entry count above ring size");

  // handles come back within the stored handle width
  a_handle_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.out_handle >> SlotHW) == '0))
    else $error("handle wider than the stored width");
`endif

endmodule

// ===== bench/tb_dedup_bounded_sample_fifo.sv =====
`timescale 1ns / 1ps
// tb_dedup_bounded_sample_fifo: self-checking bench for the dedup sample history
// drives request beats and depth_limit writes, predicts every response beat
// depends on dbsf_pkg and dedup_bounded_sample_fifo

module tb_dedup_bounded_sample_fifo;
  import dbsf_pkg::*;

  localparam int unsigned HistDepth     = MaxDepthDef;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned RecentKeys    = 24;
  localparam int unsigned AwaitDepth    = 16;
  localparam int unsigned DirRows       = 32;

  // request code with no operation behind it
  localparam logic [ReqW-1:0] ReqNop = 2'd3;

  // register map
  localparam logic [ApbAddrW-1:0] DepthLimitAddr = {RegDepthLimit, 2'b00};
  localparam logic [ApbAddrW-1:0] UnusedAddr     = {~RegDepthLimit, 2'b00};

  // directed patterns
  localparam logic [63:0] AllOnes = {64{1'b1}};
  localparam logic [63:0] PatA    = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [63:0] PatB    = 64'h5A5A_5A5A_5A5A_5A5A;

  typedef struct packed {
    logic [IdW-1:0]  wh;
    logic [IdW-1:0]  wl;
    logic [SeqW-1:0] sq;
  } hist_key_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_stall_o;
  req_t                in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rsp_t                out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // history predictor state
  logic [IdW-1:0]     hist_wh     [HistDepth];
  logic [IdW-1:0]     hist_wl     [HistDepth];
  logic [SeqW-1:0]    hist_seq    [HistDepth];
  logic [KindW-1:0]   hist_kind   [HistDepth];
  logic [HandleW-1:0] hist_handle [HistDepth];
  int unsigned        hist_head;
  int unsigned        hist_cnt;
  logic [CountW-1:0]  depth_reg;

  // stimulus bookkeeping
  rsp_t        awaited_rsp [AwaitDepth];
  int unsigned await_wr;
  int unsigned await_rd;
  hist_key_t   recent_keys [RecentKeys];
  int unsigned recent_wr;
  int unsigned recent_cnt;
  dir_row_t    dir_tab [DirRows];
  int unsigned dir_cnt;
  logic [63:0] writer_hi_pool [4];
  logic [63:0] writer_lo_pool [4];
  logic [63:0] seq_ctr;
  bit          steady;
  int unsigned fail_cnt;
  rsp_t        mon_want;
  int unsigned phase_depth [NumPhases] = '{16, 0, 31, 1, 17, 5, 16, 2, 9, 3, 12, 16};

  dedup_bounded_sample_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("dedup_bounded_sample_fifo test failed");
    $finish;
  end

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic req_t mk_req(logic [ReqW-1:0] code, logic [IdW-1:0] wh,
                                  logic [IdW-1:0] wl, logic [SeqW-1:0] sq,
                                  logic [KindW-1:0] kd, logic [HandleW-1:0] hd);
    req_t rq;
    rq.req_type       = code;
    rq.writer_id_high = wh;
    rq.writer_id_low  = wl;
    rq.seq_num        = sq;
    rq.change_kind    = kd;
    rq.payload_handle = hd;
    return rq;
  endfunction

  function automatic rsp_t mk_rsp(logic ok, logic [IdW-1:0] wh, logic [IdW-1:0] wl,
                                  logic [SeqW-1:0] sq, logic [KindW-1:0] kd,
                                  logic [HandleW-1:0] hd, logic [CountW-1:0] cnt);
    rsp_t r;
    r.ok              = ok;
    r.out_writer_high = wh;
    r.out_writer_low  = wl;
    r.out_seq         = sq;
    r.out_kind        = kd;
    r.out_handle      = hd;
    r.entry_count     = cnt;
    return r;
  endfunction

  // append one directed row
  function automatic void add_row(req_t rq, bit typed, rsp_t want);
    dir_tab[dir_cnt] = '{rq, typed, want};
    dir_cnt++;
  endfunction

  // linear scan of the held entries, oldest first
  function automatic bit key_held(logic [IdW-1:0] wh, logic [IdW-1:0] wl,
                                  logic [SeqW-1:0] sq);
    int unsigned s;
    for (int unsigned i = 0; i < hist_cnt; i++) begin
      s = (hist_head + i) % HistDepth;
      if (hist_wh[s] == wh && hist_wl[s] == wl && hist_seq[s] == sq) return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one request to the history and return the response it yields
  function automatic rsp_t history_step(req_t rq);
    rsp_t        r;
    int unsigned lim;
    int unsigned s;
    r = '0;
    case (rq.req_type)
      ReqAdd: begin
        if (!key_held(rq.writer_id_high, rq.writer_id_low, rq.seq_num)) begin
          // zero acts as one, anything above the ring size saturates
          lim = (depth_reg == 0) ? 1 : (depth_reg > HistDepth) ? HistDepth : depth_reg;
          while (hist_cnt >= lim) begin
            hist_head = (hist_head + 1) % HistDepth;
            hist_cnt--;
          end
          s = (hist_head + hist_cnt) % HistDepth;
          hist_wh[s]     = rq.writer_id_high;
          hist_wl[s]     = rq.writer_id_low;
          hist_seq[s]    = rq.seq_num;
          hist_kind[s]   = rq.change_kind;
          hist_handle[s] = rq.payload_handle;
          hist_cnt++;
          r.ok = 1'b1;
        end
      end
      ReqTake: begin
        if (hist_cnt != 0) begin
          s = hist_head;
          r.ok              = 1'b1;
          r.out_writer_high = hist_wh[s];
          r.out_writer_low  = hist_wl[s];
          r.out_seq         = hist_seq[s];
          r.out_kind        = hist_kind[s];
          r.out_handle      = hist_handle[s];
          hist_head = (hist_head + 1) % HistDepth;
          hist_cnt--;
        end
      end
      ReqContains: begin
        r.ok = key_held(rq.writer_id_high, rq.writer_id_low, rq.seq_num);
      end
      default: ;
    endcase
    r.entry_count = CountW'(hist_cnt);
    return r;
  endfunction

  // random request: recently stored keys, near misses of them and fresh keys
  function automatic req_t draw_request();
    req_t        rq;
    hist_key_t   k;
    logic [191:0] flat;
    int unsigned pick;
    int unsigned bitpos;
    int unsigned w;
    pick = $urandom_range(0, 99);
    if (pick < 50) rq.req_type = ReqAdd;
    else if (pick < 70) rq.req_type = ReqTake;
    else if (pick < 95) rq.req_type = ReqContains;
    else rq.req_type = ReqNop;
    pick = $urandom_range(0, 99);
    if (recent_cnt != 0 && pick < 55) begin
      k = recent_keys[$urandom_range(0, recent_cnt - 1)];
      if (pick >= 45) begin
        flat = k;
        bitpos = $urandom_range(0, 191);
        flat[bitpos] = ~flat[bitpos];
        k = flat;
      end
    end else begin
      w = $urandom_range(0, 3);
      if (pick < 85) begin
        k.wh = writer_hi_pool[w];
        k.wl = writer_lo_pool[w];
      end else begin
        k.wh = {$urandom, $urandom};
        k.wl = {$urandom, $urandom};
      end
      if ($urandom_range(0, 9) == 0) begin
        k.sq = {$urandom, $urandom};
      end else begin
        seq_ctr = seq_ctr + 1;
        k.sq = seq_ctr;
      end
    end
    rq.writer_id_high = k.wh;
    rq.writer_id_low  = k.wl;
    rq.seq_num        = k.sq;
    rq.change_kind    = KindW'($urandom);
    rq.payload_handle = HandleW'($urandom);
    return rq;
  endfunction

  // one request beat; valid stays high across back-to-back beats
  task automatic send_request(req_t rq, bit typed, rsp_t want);
    int unsigned gap;
    rsp_t        pred;
    hist_key_t   k;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (in_stall_o);
    pred = history_step(rq);
    if (rq.req_type == ReqAdd && pred.ok) begin
      k.wh = rq.writer_id_high;
      k.wl = rq.writer_id_low;
      k.sq = rq.seq_num;
      recent_keys[recent_wr] = k;
      recent_wr = (recent_wr + 1) % RecentKeys;
      if (recent_cnt < RecentKeys) recent_cnt++;
    end
    awaited_rsp[await_wr % AwaitDepth] = typed ? want : pred;
    await_wr++;
  endtask

  // stop sending and let every response drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (await_wr != await_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [ApbAddrW-1:0] a, logic [ApbDataW-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [ApbAddrW-1:0] a, output logic [ApbDataW-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_depth_reg();
    logic [ApbDataW-1:0] rd;
    apb_read(DepthLimitAddr, rd);
    check_field("depth_limit readback", 64'(depth_reg), 64'(rd));
  endtask

  // upper data bits are random and must be dropped by the register
  task automatic set_depth(logic [CountW-1:0] v);
    logic [ApbDataW-1:0] wd;
    wd = $urandom;
    wd[CountW-1:0] = v;
    apb_write(DepthLimitAddr, wd);
    depth_reg = v;
    check_depth_reg();
  endtask

  // response side stall pattern
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // response check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (await_wr == await_rd) begin
        $display("%0t unexpected response beat: expected none, actual %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        mon_want = awaited_rsp[await_rd % AwaitDepth];
        await_rd++;
        check_field("ok", 64'(mon_want.ok), 64'(out_data_o.ok));
        check_field("out_writer_high", mon_want.out_writer_high, out_data_o.out_writer_high);
        check_field("out_writer_low", mon_want.out_writer_low, out_data_o.out_writer_low);
        check_field("out_seq", mon_want.out_seq, out_data_o.out_seq);
        check_field("out_kind", 64'(mon_want.out_kind), 64'(out_data_o.out_kind));
        check_field("out_handle", 64'(mon_want.out_handle), 64'(out_data_o.out_handle));
        check_field("entry_count", 64'(mon_want.entry_count), 64'(out_data_o.entry_count));
      end
    end
  end

  // main sequence
  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    fail_cnt   = 0;
    steady     = 1'b0;
    hist_head  = 0;
    hist_cnt   = 0;
    await_wr   = 0;
    await_rd   = 0;
    recent_wr  = 0;
    recent_cnt = 0;
    dir_cnt    = 0;
    depth_reg  = DepthLimitRst;
    seq_ctr    = {$urandom, $urandom};
    writer_hi_pool = '{AllOnes, 64'd0, {$urandom, $urandom}, {$urandom, $urandom}};
    writer_lo_pool = '{AllOnes, 64'd0, {$urandom, $urandom}, {$urandom, $urandom}};

    // directed rows, depth_limit at its reset value
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ReqContains, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ReqNop, AllOnes, AllOnes, AllOnes, 3, 16'hFFFF), 1'b1,
            mk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ReqAdd, AllOnes, AllOnes, AllOnes, 3, 16'hFFFF), 1'b1,
            mk_rsp(1, 0, 0, 0, 0, 0, 1));
    add_row(mk_req(ReqAdd, 0, 0, 0, 0, 0), 1'b1, mk_rsp(1, 0, 0, 0, 0, 0, 2));
    // duplicate key with other kind and handle is refused
    add_row(mk_req(ReqAdd, AllOnes, AllOnes, AllOnes, 1, 16'h1234), 1'b1,
            mk_rsp(0, 0, 0, 0, 0, 0, 2));
    add_row(mk_req(ReqContains, AllOnes, AllOnes, AllOnes, 0, 0), 1'b1,
            mk_rsp(1, 0, 0, 0, 0, 0, 2));
    // near misses on seq and on writer id
    add_row(mk_req(ReqContains, AllOnes, AllOnes, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0),
            1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 2));
    add_row(mk_req(ReqContains, 64'h7FFF_FFFF_FFFF_FFFF, AllOnes, AllOnes, 0, 0),
            1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 2));
    add_row(mk_req(ReqAdd, AllOnes, 0, AllOnes, 1, 16'h0001), 1'b1,
            mk_rsp(1, 0, 0, 0, 0, 0, 3));
    add_row(mk_req(ReqAdd, PatA, PatB, PatA, 2, 16'h5A5A), 1'b0, '0);
    add_row(mk_req(ReqAdd, PatB, PatA, PatB, 1, 16'hA5A5), 1'b0, '0);
    add_row(mk_req(ReqNop, PatA, PatA, PatA, 2, 16'h5A5A), 1'b0, '0);
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(1, AllOnes, AllOnes, AllOnes, 3, 16'hFFFF, 4));
    add_row(mk_req(ReqTake, AllOnes, AllOnes, AllOnes, 3, 16'hFFFF), 1'b1,
            mk_rsp(1, 0, 0, 0, 0, 0, 3));
    add_row(mk_req(ReqContains, AllOnes, 0, AllOnes, 0, 0), 1'b0, '0);
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b0, '0);
    // empty again
    add_row(mk_req(ReqTake, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ReqContains, AllOnes, AllOnes, AllOnes, 0, 0), 1'b1,
            mk_rsp(0, 0, 0, 0, 0, 0, 0));
    // a taken key may be stored again
    add_row(mk_req(ReqAdd, 0, 0, 0, 2, 16'h8001), 1'b1,
            mk_rsp(1, 0, 0, 0, 0, 0, 1));

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_depth_reg();

    for (int unsigned i = 0; i < dir_cnt; i++) begin
      send_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
    end
    settle();

    // a write to an unmapped address leaves depth_limit alone
    apb_write(UnusedAddr, $urandom);
    check_depth_reg();

    // random phases over a sweep of depth settings
    for (int unsigned p = 0; p < NumPhases; p++) begin
      set_depth(CountW'(phase_depth[p]));
      steady = (p % 4 == 2);
      repeat (ItemsPerPhase) send_request(draw_request(), 1'b0, '0);
      settle();
    end

    if (fail_cnt == 0) begin
      $display("dedup_bounded_sample_fifo test passed");
    end else begin
      $display("dedup_bounded_sample_fifo test failed");
    end
    $finish;
  end

endmodule
